>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the bitmap allocation engine.
// Depends on nothing; the asserting module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BAE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent is followed in the next cycle by a consequent.
`define BAE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/bae_pkg.sv
// Package of the bitmap allocation engine: field widths, command and status codes,
// and the command and status structs between controller and datapath. No dependencies.
package bae_pkg;

  localparam int POS_W = 16;  // internal bit position width, holds index + length
  localparam int FLD_W = 13;  // width of positions and counts on the ports

  localparam logic [FLD_W-1:0] CFG_RESET = 13'd4096;

  localparam logic [2:0] MODE_FIND_SET  = 3'd0;
  localparam logic [2:0] MODE_FIND_CLR  = 3'd1;
  localparam logic [2:0] MODE_FIND_AREA = 3'd2;
  localparam logic [2:0] MODE_SET_RANGE = 3'd3;
  localparam logic [2:0] MODE_CLR_RANGE = 3'd4;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_RANGE     = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_READ,
    OP_FIND_EX,
    OP_LOOK_EX,
    OP_C_N,
    OP_AREA_CALC,
    OP_CHK_EX,
    OP_RNG_EX,
    OP_RES_NF,
    OP_RES_RANGE_BAD,
    OP_PC_INIT,
    OP_PC_RUN,
    OP_OUT
  } op_t;

  // Which bit vector the word scan searches; depends on the controller state only.
  typedef enum logic [1:0] {
    VS_NONE,
    VS_FIND,
    VS_LOOK,
    VS_CHK
  } vsel_t;

  typedef struct packed {
    op_t   op;
    vsel_t vsel;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       s_ge_n;
    logic       range_bad;
    logic       len_zero;
    logic       hit;
    logic       next_ge_n;
    logic       end_le_next;
    logic       area_stop;
    logic       pc_done;
    logic       clr_last;
  } dp_stat_t;

endpackage

>>> sv/bitmap_allocation_engine.sv
// Bitmap allocation engine; one command at a time, the bitmap walked one word per step.
// Each command runs a setup step, reads and examines the words of its mode (area search adds
// a check per candidate), then a population count of the used bits and a step loading the result.
// Throughput: a new command is taken the cycle after the result loads, even while it waits.
// Reset: synchronous, active low; then a clearing pass zeroes the bitmap word by word,
// during which no command is taken (configuration writes still are).
module bitmap_allocation_engine import bae_pkg::*; #(
  parameter int BITMAP_BITS = 4096,
  parameter int WORD_BITS   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: bits_in_use.
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  // Command channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // mode[2:0], start_bit[15:3], length[28:16],
                                  // alignment[40:29], zero pad
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // position[12:0], status[14:13], set_count[27:15],
                                  // all_set[28], all_clear[29], zero pad
);

  `include "assert_macros.svh"

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [FLD_W-1:0] position, set_count;
  logic [1:0]       status;
  logic             all_set, all_clear;

  // Controller: owns the state and drives in_tready and out_tvalid.
  bae_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: bitmap memory, word scan, popcount and the result register.
  bae_datapath #(
    .BITMAP_BITS (BITMAP_BITS),
    .WORD_BITS   (WORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_mode       (in_tdata[2:0]),
    .in_start_bit  (in_tdata[15:3]),
    .in_length     (in_tdata[28:16]),
    .in_alignment  (in_tdata[40:29]),
    .out_position  (position),
    .out_status    (status),
    .out_set_count (set_count),
    .out_all_set   (all_set),
    .out_all_clear (all_clear)
  );

  assign out_tdata = {2'b00, all_clear, all_set, set_count, status, position};

  // While idle, the datapath only ever loads a new transaction.
  `BAE_ASSERT(a_idle_only_load, in_tready |-> (cmd.op == OP_NONE || cmd.op == OP_LOAD), "busy op while idle")
  // A result is never written over one that is still waiting.
  `BAE_ASSERT(a_no_overwrite, (cmd.op == OP_OUT) |-> (!out_tvalid || out_tready), "result overwritten")
  // An accepted transaction makes the engine busy on the next cycle.
  `BAE_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "still ready after accept")

endmodule

>>> sv/bae_datapath.sv
// Datapath of the bitmap allocation engine: bitmap memory, word scan, range update,
// population count and result register. Depends on bae_pkg; driven by bae_ctrl.
module bae_datapath import bae_pkg::*; #(
  parameter int BITMAP_BITS = 4096,
  parameter int WORD_BITS   = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic             cfg_we,
  input  logic [FLD_W-1:0] cfg_wdata,
  input  logic [2:0]       in_mode,
  input  logic [FLD_W-1:0] in_start_bit,
  input  logic [FLD_W-1:0] in_length,
  input  logic [11:0]      in_alignment,
  output logic [FLD_W-1:0] out_position,
  output logic [1:0]       out_status,
  output logic [FLD_W-1:0] out_set_count,
  output logic             out_all_set,
  output logic             out_all_clear
);

  // WORD_BITS must be a power of two.
  localparam int LOG_W  = $clog2(WORD_BITS);
  localparam int NWORDS = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int PCW_W  = POS_W - LOG_W;
  localparam logic [POS_W:0] BMAX = (POS_W + 1)'(BITMAP_BITS);
  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

  function automatic logic [LOG_W:0] popcnt(input logic [WORD_BITS-1:0] v);
    logic [LOG_W:0] c;
    c = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      c = c + (LOG_W + 1)'(v[k]);
    end
    return c;
  endfunction

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WORD_BITS-1:0] rdata_r;

  logic [FLD_W-1:0] cfg_r;
  logic [2:0]       mode_r, mode_nxt;
  logic [FLD_W-1:0] len_r, len_nxt;
  logic [11:0]      align_r, align_nxt;
  logic [POS_W-1:0] n_r, n_nxt;
  logic [POS_W-1:0] s_r, s_nxt;
  logic [POS_W-1:0] end_r, end_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt;
  logic [POS_W-1:0] c_r, c_nxt;
  logic [FLD_W-1:0] pos_r, pos_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [POS_W-1:0] cnt_r, cnt_nxt;
  logic [PCW_W-1:0] pc_word_r, pc_word_nxt;
  logic             pend_r, pend_nxt;
  logic [POS_W-1:0] pend_base_r, pend_base_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [FLD_W-1:0] opos_r;
  logic [1:0]       ostat_r;
  logic [FLD_W-1:0] ocnt_r;
  logic             oset_r, oclr_r;

  logic [POS_W-1:0]     wbase, next_base, found, pc_base, n_in;
  logic [POS_W-1:0]     align_ext, area_idx, area_end;
  logic [LOG_W-1:0]     hk;
  logic [WORD_BITS-1:0] lo_mask, hi_mask, rng_mask, pc_mask, vec;
  logic                 hit, pc_issue, re, we;
  logic [ADDR_W-1:0]    raddr, waddr;
  logic [WORD_BITS-1:0] wdata;

  assign wbase     = {s_r[POS_W-1:LOG_W], {LOG_W{1'b0}}};
  assign next_base = wbase + POS_W'(WORD_BITS);
  assign lo_mask   = ONES << s_r[LOG_W-1:0];
  assign hi_mask   = (end_r >= next_base) ? ONES : ~(ONES << end_r[LOG_W-1:0]);
  assign rng_mask  = lo_mask & hi_mask;

  always_comb begin
    case (cmd.vsel)
      VS_FIND: vec = ((mode_r == MODE_FIND_SET) ? rdata_r : ~rdata_r) & lo_mask;
      VS_LOOK: vec = ~rdata_r & lo_mask;
      VS_CHK:  vec = rdata_r & rng_mask;
      default: vec = '0;
    endcase
  end

  // Lowest set bit of the selected vector.
  always_comb begin
    hk = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (vec[k]) begin
        hk = LOG_W'(k);
      end
    end
  end

  assign hit   = |vec;
  assign found = wbase + POS_W'(hk);

  assign align_ext = POS_W'(align_r);
  assign area_idx  = (c_r + align_ext) & ~align_ext;
  assign area_end  = area_idx + POS_W'(len_r);

  assign pc_base  = {pc_word_r, {LOG_W{1'b0}}};
  assign pc_issue = pc_base < n_r;
  assign pc_mask  = (n_r >= pend_base_r + POS_W'(WORD_BITS)) ? ONES :
                    ~(ONES << n_r[LOG_W-1:0]);

  assign n_in = ((POS_W + 1)'(cfg_r) > BMAX) ? BMAX[POS_W-1:0] : POS_W'(cfg_r);

  assign stat.mode        = mode_r;
  assign stat.s_ge_n      = s_r >= n_r;
  assign stat.range_bad   = end_r > n_r;
  assign stat.len_zero    = len_r == '0;
  assign stat.hit         = hit;
  assign stat.next_ge_n   = next_base >= n_r;
  assign stat.end_le_next = end_r <= next_base;
  assign stat.area_stop   = (area_end > n_r) || (len_r == '0);
  assign stat.pc_done     = !pc_issue && !pend_r;
  assign stat.clr_last    = clr_cnt_r == ADDR_W'(NWORDS - 1);

  // Memory ports.
  assign re    = (cmd.op == OP_READ) || ((cmd.op == OP_PC_RUN) && pc_issue);
  assign raddr = (cmd.op == OP_PC_RUN) ? pc_word_r[ADDR_W-1:0] : s_r[LOG_W +: ADDR_W];
  assign we    = (cmd.op == OP_CLR) || (cmd.op == OP_RNG_EX);
  assign waddr = (cmd.op == OP_CLR) ? clr_cnt_r : s_r[LOG_W +: ADDR_W];
  assign wdata = (cmd.op == OP_CLR) ? '0 :
                 (mode_r == MODE_SET_RANGE) ? (rdata_r | rng_mask) : (rdata_r & ~rng_mask);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    len_nxt       = len_r;
    align_nxt     = align_r;
    n_nxt         = n_r;
    s_nxt         = s_r;
    end_nxt       = end_r;
    idx_nxt       = idx_r;
    c_nxt         = c_r;
    pos_nxt       = pos_r;
    status_nxt    = status_r;
    cnt_nxt       = cnt_r;
    pc_word_nxt   = pc_word_r;
    pend_nxt      = pend_r;
    pend_base_nxt = pend_base_r;
    clr_cnt_nxt   = clr_cnt_r;
    case (cmd.op)
      OP_CLR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      OP_LOAD: begin
        mode_nxt   = in_mode;
        len_nxt    = in_length;
        align_nxt  = in_alignment;
        n_nxt      = n_in;
        s_nxt      = POS_W'(in_start_bit);
        end_nxt    = POS_W'(in_start_bit) + POS_W'(in_length);
        pos_nxt    = (in_mode == MODE_SET_RANGE || in_mode == MODE_CLR_RANGE) ?
                     in_start_bit : '0;
        status_nxt = STAT_OK;
      end
      OP_FIND_EX: begin
        if (hit) begin
          if (found >= n_r) begin
            pos_nxt    = n_r[FLD_W-1:0];
            status_nxt = STAT_NOT_FOUND;
          end else begin
            pos_nxt = found[FLD_W-1:0];
          end
        end else if (next_base >= n_r) begin
          pos_nxt    = n_r[FLD_W-1:0];
          status_nxt = STAT_NOT_FOUND;
        end else begin
          s_nxt = next_base;
        end
      end
      OP_LOOK_EX: begin
        if (hit) begin
          c_nxt = (found >= n_r) ? n_r : found;
        end else if (next_base >= n_r) begin
          c_nxt = n_r;
        end else begin
          s_nxt = next_base;
        end
      end
      OP_C_N: begin
        c_nxt = n_r;
      end
      OP_AREA_CALC: begin
        idx_nxt = area_idx;
        end_nxt = area_end;
        s_nxt   = area_idx;
        if (area_end > n_r) begin
          pos_nxt    = n_r[FLD_W-1:0];
          status_nxt = STAT_NOT_FOUND;
        end else if (len_r == '0) begin
          pos_nxt    = area_idx[FLD_W-1:0];
          status_nxt = (area_idx >= n_r) ? STAT_NOT_FOUND : STAT_OK;
        end
      end
      OP_CHK_EX: begin
        if (hit) begin
          s_nxt = found + 1'b1;
        end else if (end_r <= next_base) begin
          pos_nxt    = idx_r[FLD_W-1:0];
          status_nxt = STAT_OK;
        end else begin
          s_nxt = next_base;
        end
      end
      OP_RNG_EX: begin
        if (end_r > next_base) begin
          s_nxt = next_base;
        end
      end
      OP_RES_NF: begin
        pos_nxt    = n_r[FLD_W-1:0];
        status_nxt = STAT_NOT_FOUND;
      end
      OP_RES_RANGE_BAD: begin
        status_nxt = STAT_RANGE;
      end
      OP_PC_INIT: begin
        pc_word_nxt = '0;
        cnt_nxt     = '0;
        pend_nxt    = 1'b0;
      end
      OP_PC_RUN: begin
        pend_nxt      = pc_issue;
        pend_base_nxt = pc_base;
        if (pc_issue) begin
          pc_word_nxt = pc_word_r + 1'b1;
        end
        if (pend_r) begin
          cnt_nxt = cnt_r + POS_W'(popcnt(rdata_r & pc_mask));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= CFG_RESET;
      clr_cnt_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      clr_cnt_r <= clr_cnt_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    len_r       <= len_nxt;
    align_r     <= align_nxt;
    n_r         <= n_nxt;
    s_r         <= s_nxt;
    end_r       <= end_nxt;
    idx_r       <= idx_nxt;
    c_r         <= c_nxt;
    pos_r       <= pos_nxt;
    status_r    <= status_nxt;
    cnt_r       <= cnt_nxt;
    pc_word_r   <= pc_word_nxt;
    pend_base_r <= pend_base_nxt;
    if (cmd.op == OP_OUT) begin
      opos_r  <= pos_r;
      ostat_r <= status_r;
      ocnt_r  <= cnt_r[FLD_W-1:0];
      oset_r  <= cnt_r == n_r;
      oclr_r  <= cnt_r == '0;
    end
  end

  assign out_position  = opos_r;
  assign out_status    = ostat_r;
  assign out_set_count = ocnt_r;
  assign out_all_set   = oset_r;
  assign out_all_clear = oclr_r;

endmodule

>>> sv/bae_ctrl.sv
// Controller of the bitmap allocation engine: sequences the clearing pass, the
// word-by-word command phases and the output handshake. Depends on bae_pkg.
module bae_ctrl import bae_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_CLR     = 16'b0000_0000_0000_0001,
    S_IDLE    = 16'b0000_0000_0000_0010,
    S_SETUP   = 16'b0000_0000_0000_0100,
    S_FIND_RD = 16'b0000_0000_0000_1000,
    S_FIND_EX = 16'b0000_0000_0001_0000,
    S_LOOK    = 16'b0000_0000_0010_0000,
    S_LOOK_RD = 16'b0000_0000_0100_0000,
    S_LOOK_EX = 16'b0000_0000_1000_0000,
    S_AREA    = 16'b0000_0001_0000_0000,
    S_CHK_RD  = 16'b0000_0010_0000_0000,
    S_CHK_EX  = 16'b0000_0100_0000_0000,
    S_RNG_RD  = 16'b0000_1000_0000_0000,
    S_RNG_EX  = 16'b0001_0000_0000_0000,
    S_PC_INIT = 16'b0010_0000_0000_0000,
    S_PC_RUN  = 16'b0100_0000_0000_0000,
    S_OUT     = 16'b1000_0000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Vector select follows the state alone.
  always_comb begin
    case (state_r)
      S_FIND_EX: cmd.vsel = VS_FIND;
      S_LOOK_EX: cmd.vsel = VS_LOOK;
      S_CHK_EX:  cmd.vsel = VS_CHK;
      default:   cmd.vsel = VS_NONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        case (stat.mode)
          MODE_FIND_SET, MODE_FIND_CLR: begin
            if (stat.s_ge_n) begin
              cmd.op    = OP_RES_NF;
              state_nxt = S_PC_INIT;
            end else begin
              state_nxt = S_FIND_RD;
            end
          end
          MODE_FIND_AREA: begin
            state_nxt = S_LOOK;
          end
          MODE_SET_RANGE, MODE_CLR_RANGE: begin
            if (stat.range_bad) begin
              cmd.op    = OP_RES_RANGE_BAD;
              state_nxt = S_PC_INIT;
            end else if (stat.len_zero) begin
              state_nxt = S_PC_INIT;
            end else begin
              state_nxt = S_RNG_RD;
            end
          end
          default: begin
            state_nxt = S_PC_INIT;
          end
        endcase
      end
      S_FIND_RD: begin
        cmd.op    = OP_READ;
        state_nxt = S_FIND_EX;
      end
      S_FIND_EX: begin
        cmd.op    = OP_FIND_EX;
        state_nxt = (stat.hit || stat.next_ge_n) ? S_PC_INIT : S_FIND_RD;
      end
      S_LOOK: begin
        if (stat.s_ge_n) begin
          cmd.op    = OP_C_N;
          state_nxt = S_AREA;
        end else begin
          state_nxt = S_LOOK_RD;
        end
      end
      S_LOOK_RD: begin
        cmd.op    = OP_READ;
        state_nxt = S_LOOK_EX;
      end
      S_LOOK_EX: begin
        cmd.op    = OP_LOOK_EX;
        state_nxt = (stat.hit || stat.next_ge_n) ? S_AREA : S_LOOK_RD;
      end
      S_AREA: begin
        cmd.op    = OP_AREA_CALC;
        state_nxt = stat.area_stop ? S_PC_INIT : S_CHK_RD;
      end
      S_CHK_RD: begin
        cmd.op    = OP_READ;
        state_nxt = S_CHK_EX;
      end
      S_CHK_EX: begin
        cmd.op = OP_CHK_EX;
        if (stat.hit) begin
          state_nxt = S_LOOK;
        end else if (stat.end_le_next) begin
          state_nxt = S_PC_INIT;
        end else begin
          state_nxt = S_CHK_RD;
        end
      end
      S_RNG_RD: begin
        cmd.op    = OP_READ;
        state_nxt = S_RNG_EX;
      end
      S_RNG_EX: begin
        cmd.op    = OP_RNG_EX;
        state_nxt = stat.end_le_next ? S_PC_INIT : S_RNG_RD;
      end
      S_PC_INIT: begin
        cmd.op    = OP_PC_INIT;
        state_nxt = S_PC_RUN;
      end
      S_PC_RUN: begin
        cmd.op = OP_PC_RUN;
        if (stat.pc_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_tready) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.op == OP_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> tb/sv/tb_bitmap_allocation_engine.sv
// Self-checking testbench of bitmap_allocation_engine: directed and random commands,
// result checks against a bit-level bitmap predictor. Depends on bae_pkg and the RTL.
module tb_bitmap_allocation_engine;
  import bae_pkg::*;

  localparam int MAP_BITS   = 4096;
  localparam int STALL_LIMIT = 200000;  // idle cycles before the run is declared hung
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [12:0] position;
    logic [1:0]  status;
    logic [12:0] set_count;
    logic        all_set;
    logic        all_clear;
  } alloc_result_t;

  // Bitmap predictor and queue of outstanding results.
  class alloc_scoreboard;
    bit [MAP_BITS-1:0] alloc_map;
    int unsigned       bits_cfg;
    alloc_result_t     pending_q[$];
    int                errors;

    function new();
      alloc_map = '0;
      bits_cfg  = 4096;
      errors    = 0;
    endfunction

    function void write_bits_in_use(logic [12:0] v);
      bits_cfg = v;
    endfunction

    function int unsigned next_bit(int unsigned s, int unsigned n, bit want);
      for (int unsigned b = s; b < n; b++) begin
        if (alloc_map[b] == want) return b;
      end
      return n;
    endfunction

    // Aligned run of clear bits; restart just past any set bit in the candidate.
    function int unsigned clear_area(int unsigned s, int unsigned len, int unsigned al,
                                     int unsigned n);
      int unsigned idx, stop, i;
      while (1) begin
        idx  = (next_bit(s, n, 1'b0) + al) & ~al;
        stop = idx + len;
        if (stop > n || stop < idx) return n;
        for (i = idx; i < stop; i++) begin
          if (alloc_map[i]) break;
        end
        if (i == stop) return idx;
        s = i + 1;
      end
    endfunction

    function void note_command(logic [2:0] mode, logic [12:0] start, logic [12:0] len,
                               logic [11:0] al);
      int unsigned   n, pos, cnt;
      logic [1:0]    st;
      alloc_result_t r;
      n   = (bits_cfg > MAP_BITS) ? MAP_BITS : bits_cfg;
      pos = 0;
      st  = STAT_OK;
      if (mode == MODE_FIND_SET || mode == MODE_FIND_CLR || mode == MODE_FIND_AREA) begin
        if (mode == MODE_FIND_AREA) pos = clear_area(start, len, al, n);
        else pos = next_bit(start, n, mode == MODE_FIND_SET);
        if (pos >= n) begin
          pos = n;
          st  = STAT_NOT_FOUND;
        end
      end else if (mode == MODE_SET_RANGE || mode == MODE_CLR_RANGE) begin
        pos = start;
        if (int'(start) + int'(len) > n) st = STAT_RANGE;
        else for (int unsigned i = start; i < start + len; i++)
          alloc_map[i] = (mode == MODE_SET_RANGE);
      end
      cnt = 0;
      for (int unsigned i = 0; i < n; i++) cnt += alloc_map[i];
      r.position  = pos[12:0];
      r.status    = st;
      r.set_count = cnt[12:0];
      r.all_set   = (cnt == n);
      r.all_clear = (cnt == 0);
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] d);
      alloc_result_t e;
      if (pending_q.size() == 0) begin
        $error("result with nothing outstanding: %h", d);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (d[12:0] !== e.position) begin
        $error("position: expected %0d, got %0d", e.position, d[12:0]);
        errors++;
      end
      if (d[14:13] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, d[14:13]);
        errors++;
      end
      if (d[27:15] !== e.set_count) begin
        $error("set_count: expected %0d, got %0d", e.set_count, d[27:15]);
        errors++;
      end
      if (d[28] !== e.all_set) begin
        $error("all_set: expected %0b, got %0b", e.all_set, d[28]);
        errors++;
      end
      if (d[29] !== e.all_clear) begin
        $error("all_clear: expected %0b, got %0b", e.all_clear, d[29]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [12:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  alloc_scoreboard sb = new();
  bit              quiet = 1'b0;   // set for the final stretch: no idling on either side
  int unsigned     idle_cycles = 0;
  int unsigned     cur_n = 4096;   // used bits, steers the random ranges

  bitmap_allocation_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Check every result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Hold result ready low in random bursts.
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall == 0 && !quiet && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 16);
      if (stall != 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("bitmap_allocation_engine verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one command; called at a falling edge, returns at a falling edge.
  task automatic send_cmd(logic [2:0] mode, logic [12:0] start, logic [12:0] len,
                          logic [11:0] al);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, al, len, start, mode};
    do @(posedge clk); while (!in_tready);
    sb.note_command(mode, start, len, al);
    @(negedge clk);
  endtask

  // Drain outstanding results, then write bits_in_use while the block is idle.
  task automatic set_bits_in_use(logic [12:0] v);
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_bits_in_use(v);
    cur_n = (v > MAP_BITS) ? MAP_BITS : v;
  endtask

  // Random command biased toward well-formed ranges inside the used bits.
  task automatic send_random();
    logic [2:0]  mode;
    logic [12:0] start, len;
    logic [11:0] al;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 30)      mode = MODE_SET_RANGE;
    else if (k < 45) mode = MODE_CLR_RANGE;
    else if (k < 70) mode = MODE_FIND_AREA;
    else if (k < 82) mode = MODE_FIND_SET;
    else if (k < 95) mode = MODE_FIND_CLR;
    else             mode = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) begin
      start = 13'($urandom_range(0, 8191));
      len   = 13'($urandom_range(0, 8191));
    end else begin
      start = 13'($urandom_range(0, cur_n));
      len   = (mode == MODE_FIND_AREA) ? 13'($urandom_range(0, 24)) :
                                         13'($urandom_range(0, 40));
      if (mode >= MODE_SET_RANGE && start + len > cur_n && $urandom_range(0, 3) != 0)
        len = 13'(cur_n - start);
    end
    if ($urandom_range(0, 7) == 0) al = 12'($urandom_range(0, 4095));
    else al = (12'd1 << $urandom_range(0, 6)) - 12'd1;
    send_cmd(mode, start, len, al);
  endtask

  initial begin
    int unsigned n_list[9]  = '{64, 1, 4096, 65, 0, 300, 8191, 130, 4096};
    int unsigned cnt_list[9] = '{250, 60, 200, 200, 30, 250, 150, 300, 250};

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes of each field, every mode, boundary cases at reset size.
    send_cmd(MODE_FIND_SET,  13'd0,    13'd0,    12'd0);     // empty map: not found
    send_cmd(MODE_FIND_CLR,  13'd4095, 13'd0,    12'd0);
    send_cmd(MODE_FIND_CLR,  13'd4096, 13'd0,    12'd0);     // start at n
    send_cmd(MODE_FIND_CLR,  13'd8191, 13'd8191, 12'd4095);  // start far past n
    send_cmd(MODE_SET_RANGE, 13'd0,    13'd4096, 12'd0);     // fill the whole map
    send_cmd(MODE_FIND_CLR,  13'd0,    13'd0,    12'd0);
    send_cmd(MODE_FIND_AREA, 13'd0,    13'd1,    12'd0);
    send_cmd(MODE_CLR_RANGE, 13'd4000, 13'd97,   12'd0);     // range past n: ignored
    send_cmd(MODE_CLR_RANGE, 13'd8191, 13'd8191, 12'd0);
    send_cmd(MODE_CLR_RANGE, 13'd100,  13'd0,    12'd0);     // zero length range
    send_cmd(MODE_CLR_RANGE, 13'd3,    13'd200,  12'd0);
    send_cmd(MODE_SET_RANGE, 13'd50,   13'd1,    12'd0);
    send_cmd(MODE_FIND_AREA, 13'd0,    13'd60,   12'd7);     // restarts after bit 50
    send_cmd(MODE_FIND_AREA, 13'd1,    13'd8,    12'd5);     // mask not 2^k-1
    send_cmd(MODE_FIND_AREA, 13'd0,    13'd0,    12'd4095);  // rounds up to n
    send_cmd(MODE_FIND_AREA, 13'd0,    13'd8191, 12'd0);
    send_cmd(MODE_FIND_SET,  13'd4,    13'd0,    12'd0);
    send_cmd(MODE_FIND_SET,  13'd4095, 13'd0,    12'd0);
    send_cmd(3'd5, 13'd7, 13'd7, 12'd7);                     // unused modes
    send_cmd(3'd6, 13'd0, 13'd0, 12'd0);
    send_cmd(3'd7, 13'd8191, 13'd8191, 12'd4095);
    send_cmd(MODE_CLR_RANGE, 13'd0,    13'd4096, 12'd0);

    // Random phases, each under its own bits_in_use; the last runs without idling.
    for (int p = 0; p < 9; p++) begin
      set_bits_in_use(13'(n_list[p]));
      if (p == 8) quiet = 1'b1;
      repeat (cnt_list[p]) send_random();
    end

    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("bitmap_allocation_engine verification clean");
    end else begin
      $display("bitmap_allocation_engine verification failed");
    end
    $finish;
  end
endmodule
